// ===== sv/sat_pkg.sv =====
package sat_pkg;

    localparam int SigBits  = 17;
    localparam int AngBits  = 26;
    localparam int TableLen = 24;
    localparam int NormBits = 30;
    localparam logic signed [AngBits-1:0] Deg90  = AngBits'(90 <<< 16);
    localparam logic signed [AngBits-1:0] Deg180 = AngBits'(180 <<< 16);

    typedef logic signed [AngBits-1:0] t_ang;

    function automatic t_ang atan_deg(input int idx);
        t_ang r;
        case (idx)
            0:  r = t_ang'(2949120);
            1:  r = t_ang'(1740967);
            2:  r = t_ang'(919879);
            3:  r = t_ang'(466945);
            4:  r = t_ang'(234379);
            5:  r = t_ang'(117304);
            6:  r = t_ang'(58666);
            7:  r = t_ang'(29335);
            8:  r = t_ang'(14668);
            9:  r = t_ang'(7334);
            10: r = t_ang'(3667);
            11: r = t_ang'(1833);
            12: r = t_ang'(917);
            13: r = t_ang'(458);
            14: r = t_ang'(229);
            15: r = t_ang'(115);
            16: r = t_ang'(57);
            17: r = t_ang'(29);
            18: r = t_ang'(14);
            19: r = t_ang'(7);
            20: r = t_ang'(4);
            21: r = t_ang'(2);
            22: r = t_ang'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/signed_angle_to_target.sv =====
// Throughput: one beat per cycle; the whole pipeline advances when the output is not stalled.
// The square root resolves one root bit per stage over 31 stages, the CORDIC one iteration per stage.
// Reset clears all valid bits; payload registers are not reset.
module signed_angle_to_target #(
    parameter int COORD_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic signed [COORD_BITS-1:0]  i_center_z,
    input  logic signed [COORD_BITS-1:0]  i_forward_x,
    input  logic signed [COORD_BITS-1:0]  i_forward_y,
    input  logic signed [COORD_BITS-1:0]  i_forward_z,
    input  logic signed [COORD_BITS-1:0]  i_target_x,
    input  logic signed [COORD_BITS-1:0]  i_target_y,
    input  logic signed [COORD_BITS-1:0]  i_target_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [sat_pkg::SigBits-1:0] o_signed_angle,
    output logic                          o_degenerate
);
    import sat_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW + 1;
    localparam int NS = (PW > NormBits) ? PW - NormBits : 1;
    localparam int SqW = 2 * NormBits + 2;
    localparam int RtSteps = NormBits + 1;
    localparam int RW = NormBits + 2;
    localparam int CW = NormBits + 4;
    localparam int NC = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;

    logic adv;
    assign adv = !(o_valid && i_stall);
    assign o_stall = !adv;

    // Stage 1: difference vector.
    logic r1_v;
    logic signed [DW-1:0] r1_dx, r1_dy, r1_dz, r1_fx, r1_fy, r1_fz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
        end
        if (adv) begin
            r1_dx <= DW'(i_target_x) - DW'(i_center_x);
            r1_dy <= DW'(i_target_y) - DW'(i_center_y);
            r1_dz <= DW'(i_target_z) - DW'(i_center_z);
            r1_fx <= DW'(i_forward_x);
            r1_fy <= DW'(i_forward_y);
            r1_fz <= DW'(i_forward_z);
        end
    end

    // Stage 2: products.
    logic r2_v, r2_deg;
    logic signed [PW-1:0] r2_p [9];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
        if (adv) begin
            r2_deg <= (r1_fx == '0 && r1_fy == '0 && r1_fz == '0) ||
                      (r1_dx == '0 && r1_dy == '0 && r1_dz == '0);
            r2_p[0]  <= PW'(r1_fy * r1_dz);
            r2_p[1]  <= PW'(r1_fz * r1_dy);
            r2_p[2]  <= PW'(r1_fz * r1_dx);
            r2_p[3]  <= PW'(r1_fx * r1_dz);
            r2_p[4]  <= PW'(r1_fx * r1_dy);
            r2_p[5]  <= PW'(r1_fy * r1_dx);
            r2_p[6]  <= PW'(r1_fx * r1_dx);
            r2_p[7]  <= PW'(r1_fy * r1_dy);
            r2_p[8]  <= PW'(r1_fz * r1_dz);
        end
    end

    // Stage 3: cross components, dot product, magnitudes.
    logic r3_v, r3_deg, r3_czneg, r3_czero, r3_dneg;
    logic [PW-1:0] r3_a [4];
    logic signed [PW-1:0] n_c [4];
    always_comb begin
        n_c[0] = r2_p[0] - r2_p[1];
        n_c[1] = r2_p[2] - r2_p[3];
        n_c[2] = r2_p[4] - r2_p[5];
        n_c[3] = r2_p[6] + r2_p[7] + r2_p[8];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
        if (adv) begin
            r3_deg   <= r2_deg;
            r3_czneg <= n_c[2][PW-1];
            r3_czero <= (n_c[2] == '0);
            r3_dneg  <= n_c[3][PW-1];
            for (int k = 0; k < 4; k++) begin
                r3_a[k] <= n_c[k][PW-1] ? PW'(-n_c[k]) : PW'(n_c[k]);
            end
        end
    end

    // Stage 4: normalizing shift.
    logic r4_v, r4_deg, r4_czneg, r4_czero, r4_dneg;
    logic [NormBits-1:0] r4_a [4];
    logic [PW-1:0] n_or;
    int n_s;
    always_comb begin
        n_or = r3_a[0] | r3_a[1] | r3_a[2] | r3_a[3];
        n_s = 0;
        for (int b = 0; b < PW; b++) begin
            if (b >= NormBits && n_or[b]) begin
                n_s = b - NormBits + 1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= r3_v;
        end
        if (adv) begin
            r4_deg   <= r3_deg;
            r4_czneg <= r3_czneg;
            r4_czero <= r3_czero;
            r4_dneg  <= r3_dneg;
            for (int k = 0; k < 4; k++) begin
                r4_a[k] <= NormBits'(r3_a[k] >> n_s);
            end
        end
    end

    // Stage 5: squares.
    logic r5_v, r5_deg, r5_czneg, r5_czero, r5_dneg;
    logic [2*NormBits-1:0] r5_sq [3];
    logic [NormBits-1:0] r5_ad;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv) begin
            r5_v <= r4_v;
        end
        if (adv) begin
            r5_deg   <= r4_deg;
            r5_czneg <= r4_czneg;
            r5_czero <= r4_czero;
            r5_dneg  <= r4_dneg;
            r5_ad    <= r4_a[3];
            for (int k = 0; k < 3; k++) begin
                r5_sq[k] <= r4_a[k] * r4_a[k];
            end
        end
    end

    // Stage 6: sum of squares.
    logic r6_v, r6_deg, r6_czneg, r6_czero, r6_dneg;
    logic [SqW-1:0] r6_sum;
    logic [NormBits-1:0] r6_ad;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (adv) begin
            r6_v <= r5_v;
        end
        if (adv) begin
            r6_deg   <= r5_deg;
            r6_czneg <= r5_czneg;
            r6_czero <= r5_czero;
            r6_dneg  <= r5_dneg;
            r6_ad    <= r5_ad;
            r6_sum   <= SqW'(r5_sq[0]) + SqW'(r5_sq[1]) + SqW'(r5_sq[2]);
        end
    end

    // Square root: one root bit per stage, restoring.
    logic                q_v   [RtSteps+1];
    logic [3:0]          q_f   [RtSteps+1];
    logic [NormBits-1:0] q_ad  [RtSteps+1];
    logic [SqW-1:0]      q_rem [RtSteps+1];
    logic [RW-1:0]       q_rt  [RtSteps+1];
    always_comb begin
        q_v[0]   = r6_v;
        q_f[0]   = {r6_deg, r6_czneg, r6_czero, r6_dneg};
        q_ad[0]  = r6_ad;
        q_rem[0] = r6_sum;
        q_rt[0]  = '0;
    end
    for (genvar g = 0; g < RtSteps; g++) begin : g_sqrt
        localparam int Sh = 2 * (RtSteps - 1 - g);
        logic [SqW-1:0] n_trial;
        logic [SqW-1:0] n_cmp;
        always_comb begin
            n_trial = (SqW'(q_rt[g]) << (Sh + 2)) | (SqW'(1) << Sh);
            n_cmp   = n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                q_v[g+1] <= 1'b0;
            end else if (adv) begin
                q_v[g+1] <= q_v[g];
            end
            if (adv) begin
                q_f[g+1]  <= q_f[g];
                q_ad[g+1] <= q_ad[g];
                if (q_rem[g] >= n_cmp) begin
                    q_rem[g+1] <= q_rem[g] - n_cmp;
                    q_rt[g+1]  <= {q_rt[g][RW-2:0], 1'b1};
                end else begin
                    q_rem[g+1] <= q_rem[g];
                    q_rt[g+1]  <= {q_rt[g][RW-2:0], 1'b0};
                end
            end
        end
    end

    // CORDIC vectoring.
    logic                 c_v [NC+1];
    logic [3:0]           c_f [NC+1];
    logic signed [CW-1:0] c_x [NC+1];
    logic signed [CW-1:0] c_y [NC+1];
    t_ang                 c_z [NC+1];
    always_comb begin
        c_v[0] = q_v[RtSteps];
        c_f[0] = q_f[RtSteps];
        if (q_f[RtSteps][0]) begin
            c_x[0] = CW'(q_rt[RtSteps]);
            c_y[0] = CW'(q_ad[RtSteps]);
            c_z[0] = Deg90;
        end else begin
            c_x[0] = CW'(q_ad[RtSteps]);
            c_y[0] = CW'(q_rt[RtSteps]);
            c_z[0] = '0;
        end
    end
    for (genvar g = 0; g < NC; g++) begin : g_cordic
        logic signed [CW-1:0] n_xs, n_ys;
        always_comb begin
            n_xs = c_x[g] >>> g;
            n_ys = c_y[g] >>> g;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                c_v[g+1] <= 1'b0;
            end else if (adv) begin
                c_v[g+1] <= c_v[g];
            end
            if (adv) begin
                c_f[g+1] <= c_f[g];
                if (c_y[g] > 0) begin
                    c_x[g+1] <= c_x[g] + n_ys;
                    c_y[g+1] <= c_y[g] - n_xs;
                    c_z[g+1] <= c_z[g] + atan_deg(g);
                end else begin
                    c_x[g+1] <= c_x[g] - n_ys;
                    c_y[g+1] <= c_y[g] + n_xs;
                    c_z[g+1] <= c_z[g] - atan_deg(g);
                end
            end
        end
    end

    // Output stage.
    t_ang n_zc;
    logic signed [SigBits-1:0] n_ang;
    always_comb begin
        n_zc = c_z[NC];
        if (n_zc < 0) begin
            n_zc = '0;
        end
        if (n_zc > Deg180) begin
            n_zc = Deg180;
        end
        n_ang = SigBits'((n_zc + t_ang'(128)) >>> 8);
        if (c_f[NC][3] || c_f[NC][1]) begin
            n_ang = '0;
        end else if (c_f[NC][2]) begin
            n_ang = -n_ang;
        end
    end
    logic r_ov, r_deg;
    logic signed [SigBits-1:0] r_ang;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= c_v[NC];
        end
        if (adv) begin
            r_ang <= n_ang;
            r_deg <= c_f[NC][3];
        end
    end
    assign o_valid        = r_ov;
    assign o_signed_angle = r_ang;
    assign o_degenerate   = r_deg;

endmodule

// ===== sv/sat_checker.sv =====
module sat_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic                               o_stall,
    input logic signed [sat_pkg::SigBits-1:0] o_signed_angle,
    input logic                               o_degenerate
);
    import sat_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_signed_angle) && $stable(o_degenerate))
        else $error("output beat changed under stall");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_signed_angle <= 46080 && o_signed_angle >= -46080)
        else $error("angle out of range");

    a_degz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_signed_angle == '0)
        else $error("degenerate beat with nonzero angle");

    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

endmodule

bind signed_angle_to_target sat_checker u_sat_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_stall(o_stall), .o_signed_angle(o_signed_angle), .o_degenerate(o_degenerate)
);
